// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL. Each use expands to one
// labeled concurrent assertion clocked on aclk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define CSLR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Checked at every edge; the property itself must account for reset.
`define CSLR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) \
        else $error(msg);

`endif

// ===== rtl/cslr_pkg.sv =====
`default_nettype none

package cslr_pkg;

    localparam int WAYS      = 8;
    localparam int ADDR_BITS = 32;

    localparam int WAY_W   = $clog2(WAYS);
    localparam int CNT_W   = $clog2(WAYS + 1);

    // Fixed field widths of the streams.
    localparam int LINE_W     = 32;
    localparam int OUT_ADDR_W = 32;
    localparam int VWAY_W     = 3;
    localparam int S_TDATA_W  = 32;
    localparam int M_FIELDS_W = 3 + OUT_ADDR_W + VWAY_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam int LFSR_W    = 16;

    typedef logic [WAY_W-1:0]     way_t;
    typedef logic [WAY_W-1:0]     rank_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [ADDR_BITS-1:0] tag_t;
    typedef logic [LFSR_W-1:0]    lfsr_t;

    localparam lfsr_t    LFSR_TAPS   = 16'hB400;
    localparam lfsr_t    LFSR_ONE    = 16'h0001;
    localparam rank_t    RANK_OLDEST = rank_t'(WAYS - 1);
    localparam cnt_t     CNT_FULL    = cnt_t'(WAYS);

    localparam logic MODE_LRU   = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    typedef enum logic [1:0] {
        REG_MODE  = 2'd0,
        REG_ALLOC = 2'd1,
        REG_SEED  = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_COMMIT
    } state_t;

    // Passed from cell to cell along the row.
    typedef struct packed {
        logic  hit;
        way_t  hit_way;
        way_t  lru_way;
        tag_t  sel_tag;
        rank_t sel_rank;
    } chain_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic  touch;
        logic  touch_all;
        logic  tag_we;
        way_t  way;
        rank_t old_rank;
        tag_t  tag;
    } cmd_t;

    function automatic lfsr_t lfsr_step(lfsr_t v);
        lfsr_t shifted;
        shifted = v >> 1;
        return v[0] ? (shifted ^ LFSR_TAPS) : shifted;
    endfunction

    function automatic lfsr_t seed_to_lfsr(lfsr_t s);
        return (s == '0) ? LFSR_ONE : s;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cslr_cell.sv =====
`default_nettype none

module cslr_cell (
    input  wire logic            aclk,
    input  wire cslr_pkg::way_t  way_idx,
    input  wire cslr_pkg::cnt_t  fill_cnt,
    input  wire cslr_pkg::cmd_t  cmd,
    input  wire cslr_pkg::chain_t chain_in,
    output cslr_pkg::chain_t     chain_out
);

    cslr_pkg::tag_t  tag_reg;
    cslr_pkg::tag_t  tag_next;
    cslr_pkg::rank_t rank_reg;
    cslr_pkg::rank_t rank_next;

    logic filled;
    logic match;
    logic is_sel;
    logic oldest;

    always_comb begin
        // Ways fill in index order, so a way is in use when its index is
        // below the fill count.
        filled = cslr_pkg::cnt_t'(way_idx) < fill_cnt;
        match  = filled && (tag_reg == cmd.tag);
        is_sel = (way_idx == cmd.way);
        oldest = filled && (rank_reg == cslr_pkg::RANK_OLDEST);
    end

    always_comb begin
        chain_out = chain_in;
        if (match) begin
            chain_out.hit     = 1'b1;
            chain_out.hit_way = way_idx;
        end
        if (oldest) begin
            chain_out.lru_way = way_idx;
        end
        if (is_sel) begin
            chain_out.sel_tag  = tag_reg;
            chain_out.sel_rank = rank_reg;
        end
    end

    always_comb begin
        tag_next  = tag_reg;
        rank_next = rank_reg;
        if (cmd.tag_we && is_sel) begin
            tag_next = cmd.tag;
        end
        if (cmd.touch) begin
            if (is_sel) begin
                rank_next = '0;
            end else if (filled && (cmd.touch_all || rank_reg < cmd.old_rank)) begin
                rank_next = cslr_pkg::rank_t'(rank_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        tag_reg  <= tag_next;
        rank_reg <= rank_next;
    end

endmodule

`default_nettype wire

// ===== rtl/cslr_rand.sv =====
`default_nettype none

module cslr_rand (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            load,
    input  wire cslr_pkg::lfsr_t load_seed,
    input  wire logic            advance,
    output cslr_pkg::way_t       way
);

    cslr_pkg::lfsr_t    lfsr_reg;
    cslr_pkg::lfsr_t    lfsr_next;
    cslr_pkg::lfsr_t    lfsr_adv;

    assign lfsr_adv = cslr_pkg::lfsr_step(lfsr_reg);

    always_comb begin
        lfsr_next = lfsr_reg;
        if (load) begin
            lfsr_next = cslr_pkg::seed_to_lfsr(load_seed);
        end else if (advance) begin
            lfsr_next = lfsr_adv;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lfsr_reg <= cslr_pkg::LFSR_ONE;
        end else begin
            lfsr_reg <= lfsr_next;
        end
    end

    // The way count is a power of two, so the remainder of the advanced
    // value is just its low bits.
    assign way = lfsr_adv[cslr_pkg::WAY_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/cache_set_lru_random_replace.sv =====
// One set of an 8-way tag store. Each access (s_tuser = 0 read, 1 write,
// s_tdata = line address) gives one result: hit, allocated, evicted, the
// displaced address and the way hit or written. The ways form a row of
// cells that compare the address in parallel and pass the hit way, the
// least recently used way and the selected way's tag down the row. An
// access passes the idle state, which accepts it, the lookup state for
// the cell row and the commit state, which updates the cells and loads
// the output register; the next access is accepted after the commit. A
// random-mode eviction adds no state: the way is the low bits of the
// advanced LFSR value. A result not taken holds the commit state until
// the output register frees up. There is no clearing pass after reset.
`default_nettype none

`include "assert_macros.svh"

module cache_set_lru_random_replace (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [cslr_pkg::S_TDATA_W-1:0]    s_tdata,  // [31:0] line address
    input  wire logic                              s_tuser,  // [0] kind

    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [0] hit, [1] allocated, [2] evicted, [34:3] evicted_addr,
    // [37:35] victim_way, [39:38] zero
    output logic [cslr_pkg::M_TDATA_W-1:0]         m_tdata,

    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [cslr_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [cslr_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [cslr_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                   pready
);

    cslr_pkg::state_t state_reg;
    cslr_pkg::state_t state_next;

    logic            mode_reg;
    logic            mode_next;
    logic            alloc_rd_reg;
    logic            alloc_rd_next;
    cslr_pkg::lfsr_t seed_reg;
    cslr_pkg::lfsr_t seed_next;

    cslr_pkg::cnt_t  fill_cnt_reg;
    cslr_pkg::cnt_t  fill_cnt_next;

    logic            kind_reg;
    cslr_pkg::tag_t  addr_reg;
    logic            hit_reg;
    cslr_pkg::way_t  hit_way_reg;
    cslr_pkg::way_t  lru_way_reg;

    logic                          m_tvalid_reg;
    logic                          m_tvalid_next;
    logic [cslr_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [cslr_pkg::M_TDATA_W-1:0] m_tdata_next;

    cslr_pkg::chain_t chain_w [cslr_pkg::WAYS+1];
    cslr_pkg::cmd_t   cmd;

    logic s_accept;
    logic cfg_write;
    cslr_pkg::reg_idx_t reg_idx;

    logic out_free;
    logic lookup_en;
    logic commit;

    logic           alloc;
    logic           full;
    logic           fill;
    logic           evict;
    cslr_pkg::way_t vway;

    cslr_pkg::way_t rand_way;

    logic [cslr_pkg::ADDR_BITS+cslr_pkg::LINE_W-1:0]     in_wide;
    logic [cslr_pkg::ADDR_BITS+cslr_pkg::OUT_ADDR_W-1:0] ev_wide;
    logic [cslr_pkg::WAY_W+cslr_pkg::VWAY_W-1:0]         vway_wide;
    logic [cslr_pkg::OUT_ADDR_W-1:0]                     out_ev_addr;
    logic [cslr_pkg::VWAY_W-1:0]                         out_vway;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = cslr_pkg::reg_idx_t'(paddr[cslr_pkg::APB_ADDR_W-1:2]);

    always_comb begin
        mode_next     = mode_reg;
        alloc_rd_next = alloc_rd_reg;
        seed_next     = seed_reg;
        if (cfg_write) begin
            unique case (reg_idx)
                cslr_pkg::REG_MODE:  mode_next     = pwdata[0];
                cslr_pkg::REG_ALLOC: alloc_rd_next = pwdata[0];
                cslr_pkg::REG_SEED:  seed_next     = pwdata[cslr_pkg::LFSR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            cslr_pkg::REG_MODE:  prdata = cslr_pkg::APB_DATA_W'(mode_reg);
            cslr_pkg::REG_ALLOC: prdata = cslr_pkg::APB_DATA_W'(alloc_rd_reg);
            cslr_pkg::REG_SEED:  prdata = cslr_pkg::APB_DATA_W'(seed_reg);
            default:             prdata = '0;
        endcase
    end

    // Cell row.
    assign chain_w[0] = '0;

    for (genvar g = 0; g < cslr_pkg::WAYS; g++) begin : g_cell
        cslr_cell u_cell (
            .aclk      (aclk),
            .way_idx   (cslr_pkg::way_t'(g)),
            .fill_cnt  (fill_cnt_reg),
            .cmd       (cmd),
            .chain_in  (chain_w[g]),
            .chain_out (chain_w[g+1])
        );
    end

    cslr_rand u_rand (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (cfg_write && (reg_idx == cslr_pkg::REG_SEED)),
        .load_seed (pwdata[cslr_pkg::LFSR_W-1:0]),
        .advance   (commit && evict && (mode_reg != cslr_pkg::MODE_LRU)),
        .way       (rand_way)
    );

    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign full     = (fill_cnt_reg == cslr_pkg::CNT_FULL);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            cslr_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = cslr_pkg::ST_LOOKUP;
                end
            end
            cslr_pkg::ST_LOOKUP: begin
                state_next = cslr_pkg::ST_COMMIT;
            end
            cslr_pkg::ST_COMMIT: begin
                if (out_free) begin
                    state_next = cslr_pkg::ST_IDLE;
                end
            end
            default: state_next = cslr_pkg::ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        s_tready   = 1'b0;
        lookup_en  = 1'b0;
        commit     = 1'b0;
        unique case (state_reg)
            cslr_pkg::ST_IDLE:   s_tready = 1'b1;
            cslr_pkg::ST_LOOKUP: lookup_en = 1'b1;
            cslr_pkg::ST_COMMIT: commit = out_free;
            default: ;
        endcase
    end

    // Decision for the update cycle, from the registered lookup.
    always_comb begin
        alloc = !hit_reg && ((kind_reg == cslr_pkg::KIND_WRITE) || alloc_rd_reg);
        fill  = alloc && !full;
        evict = alloc && full;
        if (hit_reg) begin
            vway = hit_way_reg;
        end else if (!full) begin
            vway = fill_cnt_reg[cslr_pkg::WAY_W-1:0];
        end else if (mode_reg != cslr_pkg::MODE_LRU) begin
            vway = rand_way;
        end else begin
            vway = lru_way_reg;
        end
    end

    always_comb begin
        cmd.way       = vway;
        cmd.tag       = addr_reg;
        cmd.touch_all = fill;
        // The selected way's rank comes back along the row.
        cmd.old_rank  = chain_w[cslr_pkg::WAYS].sel_rank;
        cmd.tag_we    = commit && alloc;
        cmd.touch     = commit && (alloc || (hit_reg && (mode_reg == cslr_pkg::MODE_LRU)));
    end

    always_comb begin
        fill_cnt_next = fill_cnt_reg;
        if (commit && fill) begin
            fill_cnt_next = cslr_pkg::cnt_t'(fill_cnt_reg + 1'b1);
        end
    end

    // Result formatting.
    always_comb begin
        in_wide     = {{cslr_pkg::ADDR_BITS{1'b0}}, s_tdata};
        ev_wide     = {{cslr_pkg::OUT_ADDR_W{1'b0}}, chain_w[cslr_pkg::WAYS].sel_tag};
        vway_wide   = {{cslr_pkg::VWAY_W{1'b0}}, vway};
        out_ev_addr = evict ? ev_wide[cslr_pkg::OUT_ADDR_W-1:0] : '0;
        out_vway    = (hit_reg || alloc) ? vway_wide[cslr_pkg::VWAY_W-1:0] : '0;

        m_tdata_next = m_tdata_reg;
        if (commit) begin
            m_tdata_next = {{cslr_pkg::M_PAD_W{1'b0}}, out_vway, out_ev_addr,
                            evict, alloc, hit_reg};
        end

        m_tvalid_next = m_tvalid_reg;
        if (commit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= cslr_pkg::ST_IDLE;
            mode_reg     <= 1'b0;
            alloc_rd_reg <= 1'b1;
            seed_reg     <= cslr_pkg::LFSR_ONE;
            fill_cnt_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            alloc_rd_reg <= alloc_rd_next;
            seed_reg     <= seed_next;
            fill_cnt_reg <= fill_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        if (s_accept) begin
            kind_reg <= s_tuser;
            addr_reg <= in_wide[cslr_pkg::ADDR_BITS-1:0];
        end
        if (lookup_en) begin
            hit_reg     <= chain_w[cslr_pkg::WAYS].hit;
            hit_way_reg <= chain_w[cslr_pkg::WAYS].hit_way;
            lru_way_reg <= chain_w[cslr_pkg::WAYS].lru_way;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `CSLR_ASSERT(a_accept_to_lookup, s_accept |=> state_reg == cslr_pkg::ST_LOOKUP,
        "accepted access did not enter lookup")
    `CSLR_ASSERT(a_fill_bound, fill_cnt_reg <= cslr_pkg::CNT_FULL,
        "fill count exceeds way count")
    `CSLR_ASSERT_ALWAYS(a_fill_only_on_commit, (aresetn && !commit) |=> $stable(fill_cnt_reg),
        "fill count changed outside an update")
    `CSLR_ASSERT(a_out_hold, (m_tvalid_reg && !m_tready) |=>
        (m_tvalid_reg && $stable(m_tdata_reg)), "waiting result changed")
    `CSLR_ASSERT(a_evict_consistent, (m_tvalid_reg && m_tdata_reg[2]) |->
        (m_tdata_reg[1] && !m_tdata_reg[0]),
        "eviction reported without allocation or with a hit")
    `CSLR_ASSERT(a_commit_loads_out, commit |=> m_tvalid_reg,
        "update did not present a result")

endmodule

`default_nettype wire
